### src/brdc_pkg.sv
`timescale 1ns / 1ps

package brdc_pkg;

    // Region length limit and the counter widths that follow from it
    localparam int unsigned MAX_REGION_BYTES = 1048576;
    localparam int unsigned COUNT_W          = $clog2(MAX_REGION_BYTES + 2);
    localparam int unsigned PAIR_W           = $clog2(MAX_REGION_BYTES / 2 + 1);
    localparam int unsigned P5_W             = COUNT_W + 3;

    // Field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RUN_W    = 8;
    localparam int unsigned WORD_W   = 2;
    localparam int unsigned NUL_W    = 4;
    localparam int unsigned REASON_W = 3;
    localparam int unsigned APB_AW   = 5;
    localparam int unsigned APB_DW   = 32;

    // Constants of the classification rules
    localparam logic [6:0]         PRINT_LO      = 7'h20;
    localparam logic [6:0]         PRINT_HI      = 7'h7F;
    localparam logic [NUL_W-1:0]   NUL_PREFIX_CAP = 4'd10;
    localparam logic [WORD_W-1:0]  WORD_MAX      = 2'd3;
    localparam logic [WORD_W-1:0]  WORDS_NEEDED  = 2'd2;
    localparam logic [COUNT_W-1:0] SHORT_LIMIT   = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] TABLE_MIN     = COUNT_W'(8);

    // Register reset values
    localparam logic [RUN_W-1:0] LONG_RUN_RST  = 8'd20;
    localparam logic [RUN_W-1:0] DENSE_RUN_RST = 8'd10;
    localparam logic [RUN_W-1:0] WORD_RUN_RST  = 8'd5;
    localparam logic [RUN_W-1:0] REPEAT_RST    = 8'd4;
    localparam logic [NUL_W-1:0] NUL_PREFIX_RST = 4'd3;

    // Verdict reason codes
    typedef enum logic [REASON_W-1:0] {
        REASON_NONE    = 3'd0,
        REASON_SHORT   = 3'd1,
        REASON_LONG    = 3'd2,
        REASON_DENSE   = 3'd3,
        REASON_WORDS   = 3'd4,
        REASON_REPEAT  = 3'd5,
        REASON_NUL     = 3'd6,
        REASON_ADDRTAB = 3'd7
    } reason_t;

    // Register index (byte address / 4)
    typedef enum logic [2:0] {
        REG_LONG_RUN   = 3'd0,
        REG_DENSE_RUN  = 3'd1,
        REG_WORD_RUN   = 3'd2,
        REG_REPEAT     = 3'd3,
        REG_NUL_PREFIX = 3'd4
    } reg_idx_t;

    // Result item as packed into the output tdata
    typedef struct packed {
        logic    too_long;
        reason_t reason;
        logic    is_data;
    } verdict_t;

    // Saturating increment of a run counter
    function automatic logic [RUN_W-1:0] sat_inc8(input logic [RUN_W-1:0] v);
        sat_inc8 = (v == {RUN_W{1'b1}}) ? v : v + RUN_W'(1);
    endfunction

endpackage

### src/byte_region_data_classifier_core.sv
`timescale 1ns / 1ps

// Byte region data/code classifier.
// Input stream (s_axis_*): one byte of the region per transaction in address
// order, tlast set on the final byte. Output stream (m_axis_*): one verdict
// transaction per region, carrying is_data, the first rule that fired and the
// too_long flag. Rule thresholds sit in five registers on the APB port at
// byte addresses 0x00..0x10; write them only while no region is in flight.
// Throughput: one byte per cycle, sustained, as long as the output side takes
// verdicts; the per-byte counter update and the verdict compares sit in one
// stage between the input register and the output register.
// The final byte is held in the input register, then its verdict in the output
// register. When the receiver stalls, the verdict holds in the output register
// and bytes keep flowing; only a further final byte waits in the input register
// until the pending verdict is taken.
// Reset (rst_n low, asynchronous) empties both registers, clears all region
// counters and returns the thresholds to 20, 10, 5, 4 and 3.
module byte_region_data_classifier_core
    import brdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] byte_value
    input  logic              s_axis_tlast,   // last_byte
    // Output stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] is_data, [3:1] reason, [4] too_long
    // Configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    // Configuration registers
    logic [RUN_W-1:0] long_run_min_reg, dense_run_min_reg, word_run_min_reg, repeat_min_reg;
    logic [NUL_W-1:0] nul_prefix_min_reg;

    // Input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    // Region state
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [COUNT_W-1:0] printable_count_reg, printable_count_next;
    logic [RUN_W-1:0]   current_run_reg, current_run_next;
    logic [RUN_W-1:0]   longest_run_reg, longest_run_next;
    logic [WORD_W-1:0]  word_count_reg, word_count_next;
    logic [BYTE_W-1:0]  previous_byte_reg, previous_byte_next;
    logic [RUN_W-1:0]   same_run_reg, same_run_next;
    logic [RUN_W-1:0]   longest_same_run_reg, longest_same_run_next;
    logic               nul_string_seen_reg, nul_string_seen_next;
    logic               pending_pair_hit_reg, pending_pair_hit_next;
    logic [PAIR_W-1:0]  pair_hits_reg, pair_hits_next;

    // Output register
    logic     out_valid_reg, out_valid_next;
    verdict_t out_data_reg, out_data_next;

    // Working signals of the processing stage
    logic               proc_fire;
    logic               printable, first, sat;
    logic [6:0]         low7;
    logic [NUL_W-1:0]   nul_before;
    logic [BYTE_W-1:0]  b;
    logic [WORD_W-1:0]  word_final;
    logic [P5_W-1:0]    p5, total4, total3;
    verdict_t           verdict;
    logic               cfg_write;

    // ---------------- Configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            long_run_min_reg   <= LONG_RUN_RST;
            dense_run_min_reg  <= DENSE_RUN_RST;
            word_run_min_reg   <= WORD_RUN_RST;
            repeat_min_reg     <= REPEAT_RST;
            nul_prefix_min_reg <= NUL_PREFIX_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:2])
                REG_LONG_RUN:   long_run_min_reg   <= pwdata[RUN_W-1:0];
                REG_DENSE_RUN:  dense_run_min_reg  <= pwdata[RUN_W-1:0];
                REG_WORD_RUN:   word_run_min_reg   <= pwdata[RUN_W-1:0];
                REG_REPEAT:     repeat_min_reg     <= pwdata[RUN_W-1:0];
                REG_NUL_PREFIX: nul_prefix_min_reg <= pwdata[NUL_W-1:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (paddr[4:2])
            REG_LONG_RUN:   prdata = APB_DW'(long_run_min_reg);
            REG_DENSE_RUN:  prdata = APB_DW'(dense_run_min_reg);
            REG_WORD_RUN:   prdata = APB_DW'(word_run_min_reg);
            REG_REPEAT:     prdata = APB_DW'(repeat_min_reg);
            REG_NUL_PREFIX: prdata = APB_DW'(nul_prefix_min_reg);
            default:        prdata = '0;
        endcase
    end

    // ---------------- Flow control ----------------
    // A final byte may only move on when the output register is free or its verdict is taken
    assign proc_fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (proc_fire)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    // ---------------- Per-byte update ----------------
    assign b          = in_byte_reg;
    assign low7       = b[6:0];
    assign printable  = (low7 >= PRINT_LO) && (low7 < PRINT_HI);
    assign first      = (byte_count_reg == '0);
    assign sat        = (byte_count_reg > COUNT_W'(MAX_REGION_BYTES));
    assign nul_before = (current_run_reg < RUN_W'(NUL_PREFIX_CAP)) ?
                        current_run_reg[NUL_W-1:0] : NUL_PREFIX_CAP;

    always_comb
    begin
        byte_count_next       = byte_count_reg;
        printable_count_next  = printable_count_reg;
        current_run_next      = current_run_reg;
        longest_run_next      = longest_run_reg;
        word_count_next       = word_count_reg;
        previous_byte_next    = previous_byte_reg;
        same_run_next         = same_run_reg;
        longest_same_run_next = longest_same_run_reg;
        nul_string_seen_next  = nul_string_seen_reg;
        pending_pair_hit_next = pending_pair_hit_reg;
        pair_hits_next        = pair_hits_reg;

        // Zero byte closing a printable prefix
        if (b == '0 && !in_last_reg && nul_before >= nul_prefix_min_reg)
            nul_string_seen_next = 1'b1;

        // Little-endian pairs: a hit counts once a further byte arrives
        if (!sat)
        begin
            pair_hits_next        = pair_hits_reg + PAIR_W'(pending_pair_hit_reg);
            pending_pair_hit_next = byte_count_reg[0] && (b == '0 || b[7:3] != '0);
        end

        // Identical byte runs
        if (first)
            previous_byte_next = b;
        else if (b == previous_byte_reg)
        begin
            same_run_next = sat_inc8(same_run_reg);
            if (same_run_next > longest_same_run_reg)
                longest_same_run_next = same_run_next;
        end
        else
        begin
            same_run_next      = RUN_W'(1);
            previous_byte_next = b;
        end

        // Printable runs and words
        if (printable)
        begin
            if (!sat)
                printable_count_next = printable_count_reg + COUNT_W'(1);
            current_run_next = sat_inc8(current_run_reg);
            if (current_run_next > longest_run_reg)
                longest_run_next = current_run_next;
        end
        else
        begin
            if (current_run_reg >= word_run_min_reg && word_count_reg < WORD_MAX)
                word_count_next = word_count_reg + WORD_W'(1);
            current_run_next = '0;
        end

        if (!sat)
            byte_count_next = byte_count_reg + COUNT_W'(1);
    end

    // ---------------- Verdict on the final byte ----------------
    assign word_final = (current_run_next >= word_run_min_reg && word_count_next < WORD_MAX) ?
                        word_count_next + WORD_W'(1) : word_count_next;
    assign p5     = {printable_count_next, 2'b00} + P5_W'(printable_count_next);
    assign total4 = P5_W'({byte_count_next, 2'b00});
    assign total3 = P5_W'({byte_count_next, 1'b0}) + P5_W'(byte_count_next);

    always_comb
    begin
        verdict.is_data  = 1'b1;
        verdict.too_long = (byte_count_next > COUNT_W'(MAX_REGION_BYTES));
        priority if (byte_count_next < SHORT_LIMIT)
        begin
            verdict.reason  = REASON_SHORT;
            verdict.is_data = 1'b0;
        end
        else if (longest_run_next >= long_run_min_reg)
            verdict.reason = REASON_LONG;
        else if (p5 > total4 && longest_run_next >= dense_run_min_reg)
            verdict.reason = REASON_DENSE;
        else if (word_final >= WORDS_NEEDED && p5 > total3)
            verdict.reason = REASON_WORDS;
        else if (longest_same_run_next >= repeat_min_reg)
            verdict.reason = REASON_REPEAT;
        else if (nul_string_seen_next)
            verdict.reason = REASON_NUL;
        else if (byte_count_next >= TABLE_MIN &&
                 COUNT_W'(pair_hits_next) >= (byte_count_next >> 2))
            verdict.reason = REASON_ADDRTAB;
        else
        begin
            verdict.reason  = REASON_NONE;
            verdict.is_data = 1'b0;
        end
    end

    // Region state register: cleared after each final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg       <= '0;
            printable_count_reg  <= '0;
            current_run_reg      <= '0;
            longest_run_reg      <= '0;
            word_count_reg       <= '0;
            previous_byte_reg    <= '0;
            same_run_reg         <= RUN_W'(1);
            longest_same_run_reg <= '0;
            nul_string_seen_reg  <= 1'b0;
            pending_pair_hit_reg <= 1'b0;
            pair_hits_reg        <= '0;
        end
        else if (proc_fire)
        begin
            if (in_last_reg)
            begin
                byte_count_reg       <= '0;
                printable_count_reg  <= '0;
                current_run_reg      <= '0;
                longest_run_reg      <= '0;
                word_count_reg       <= '0;
                previous_byte_reg    <= '0;
                same_run_reg         <= RUN_W'(1);
                longest_same_run_reg <= '0;
                nul_string_seen_reg  <= 1'b0;
                pending_pair_hit_reg <= 1'b0;
                pair_hits_reg        <= '0;
            end
            else
            begin
                byte_count_reg       <= byte_count_next;
                printable_count_reg  <= printable_count_next;
                current_run_reg      <= current_run_next;
                longest_run_reg      <= longest_run_next;
                word_count_reg       <= word_count_next;
                previous_byte_reg    <= previous_byte_next;
                same_run_reg         <= same_run_next;
                longest_same_run_reg <= longest_same_run_next;
                nul_string_seen_reg  <= nul_string_seen_next;
                pending_pair_hit_reg <= pending_pair_hit_next;
                pair_hits_reg        <= pair_hits_next;
            end
        end
    end

    // ---------------- Output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (proc_fire && in_last_reg)
        begin
            out_valid_next = 1'b1;
            out_data_next  = verdict;
        end
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_data_reg};

endmodule

### src/brdc_checker.sv
`timescale 1ns / 1ps

// Port-level checks of the classifier
module brdc_checker
    import brdc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       pready
);

    // A stalled verdict stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict changed while stalled");

    // Code verdicts carry only the no-rule or short-region reason
    a_code_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (!m_axis_tdata[0] ==
            (m_axis_tdata[3:1] == REASON_NONE || m_axis_tdata[3:1] == REASON_SHORT)))
        else $error("is_data does not match reason");

    // An oversized region can never be a short one
    a_too_long: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[4] |-> m_axis_tdata[3:1] != REASON_SHORT)
        else $error("too_long with short region reason");

    // Unused tdata padding stays zero
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:5] == 3'b000)
        else $error("nonzero tdata padding");

    // Configuration port never inserts wait states
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind byte_region_data_classifier_core brdc_checker u_brdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

### tb/sv/brdc_verdict_checker.sv
`timescale 1ns / 1ps

// Region verdict checker: watches the byte stream, the verdict stream and the
// register port, predicts each region's verdict and compares it field by field.
module brdc_verdict_checker
    import brdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] byte_value
    input  logic              s_axis_tlast,   // last_byte
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [7:0]        m_axis_tdata,   // [0] is_data, [3:1] reason, [4] too_long
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    input  logic              pready,
    output int                errors,
    output int                outstanding
);

    // Threshold copies
    logic [RUN_W-1:0]   thr_long;
    logic [RUN_W-1:0]   thr_dense;
    logic [RUN_W-1:0]   thr_word;
    logic [RUN_W-1:0]   thr_repeat;
    logic [NUL_W-1:0]   thr_nul;

    // Per-region counts
    logic [COUNT_W-1:0] n_bytes;
    logic [COUNT_W-1:0] n_printable;
    logic [RUN_W-1:0]   run_len;
    logic [RUN_W-1:0]   best_run;
    logic [WORD_W-1:0]  n_words;
    logic [7:0]         last_seen;
    logic [RUN_W-1:0]   same_len;
    logic [RUN_W-1:0]   best_same;
    logic               nul_str;
    logic               hit_pending;
    logic [PAIR_W-1:0]  n_hits;

    verdict_t           expected_verdicts[$];

    task automatic start_region();
        n_bytes     = '0;
        n_printable = '0;
        run_len     = '0;
        best_run    = '0;
        n_words     = '0;
        last_seen   = '0;
        same_len    = RUN_W'(1);
        best_same   = '0;
        nul_str     = 1'b0;
        hit_pending = 1'b0;
        n_hits      = '0;
    endtask

    // Fold one accepted byte into the region counts; on the final byte
    // queue the verdict and start over
    task automatic tally_byte(input logic [7:0] b, input logic fin);
        logic              printable;
        logic              first;
        logic              frozen;
        logic [15:0]       pair;
        logic [NUL_W-1:0]  prefix;
        longint unsigned   p5;
        longint unsigned   total;
        verdict_t          v;

        printable = (b[6:0] >= PRINT_LO) && (b[6:0] < PRINT_HI);
        first     = (n_bytes == 0);
        frozen    = (n_bytes > MAX_REGION_BYTES);

        // zero byte after enough printables, not on the final byte
        if (b == 8'h00 && !fin) begin
            prefix = (run_len < 10) ? NUL_W'(run_len) : NUL_W'(10);
            if (prefix >= thr_nul)
                nul_str = 1'b1;
        end

        // little-endian pairs; a hit counts only once another byte arrives
        if (!frozen) begin
            n_hits      = n_hits + hit_pending;
            hit_pending = 1'b0;
            if (n_bytes[0]) begin
                pair        = {b, last_seen};
                hit_pending = (pair >= 16'h0800) || (pair < 16'h0100);
            end
        end

        // identical byte runs
        if (first) begin
            last_seen = b;
        end else if (b == last_seen) begin
            if (same_len != '1)
                same_len = same_len + 1'b1;
            if (same_len > best_same)
                best_same = same_len;
        end else begin
            same_len  = RUN_W'(1);
            last_seen = b;
        end

        // printable runs and words
        if (printable) begin
            if (!frozen)
                n_printable = n_printable + 1'b1;
            if (run_len != '1)
                run_len = run_len + 1'b1;
            if (run_len > best_run)
                best_run = run_len;
        end else begin
            if (run_len >= thr_word && n_words != '1)
                n_words = n_words + 1'b1;
            run_len = '0;
        end

        if (!frozen)
            n_bytes = n_bytes + 1'b1;

        if (fin) begin
            if (run_len >= thr_word && n_words != '1)
                n_words = n_words + 1'b1;

            total      = n_bytes;
            p5         = longint'(n_printable) * 5;
            v.is_data  = 1'b1;
            v.too_long = (n_bytes > MAX_REGION_BYTES);

            // first rule that fires wins
            if (n_bytes < 4) begin
                v.reason  = REASON_SHORT;
                v.is_data = 1'b0;
            end else if (best_run >= thr_long)
                v.reason = REASON_LONG;
            else if (p5 > total * 4 && best_run >= thr_dense)
                v.reason = REASON_DENSE;
            else if (n_words >= 2 && p5 > total * 3)
                v.reason = REASON_WORDS;
            else if (best_same >= thr_repeat)
                v.reason = REASON_REPEAT;
            else if (nul_str)
                v.reason = REASON_NUL;
            else if (n_bytes >= 8 && n_hits >= n_bytes / 4)
                v.reason = REASON_ADDRTAB;
            else begin
                v.reason  = REASON_NONE;
                v.is_data = 1'b0;
            end

            expected_verdicts.push_back(v);
            start_region();
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        int       bad;
        verdict_t got;
        verdict_t want;

        if (!rst_n) begin
            thr_long   = LONG_RUN_RST;
            thr_dense  = DENSE_RUN_RST;
            thr_word   = WORD_RUN_RST;
            thr_repeat = REPEAT_RST;
            thr_nul    = NUL_PREFIX_RST;
            start_region();
            expected_verdicts.delete();
            errors      <= 0;
            outstanding <= 0;
        end else begin
            bad = 0;

            // register write transaction
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[APB_AW-1:2]))
                    REG_LONG_RUN:   thr_long   = pwdata[RUN_W-1:0];
                    REG_DENSE_RUN:  thr_dense  = pwdata[RUN_W-1:0];
                    REG_WORD_RUN:   thr_word   = pwdata[RUN_W-1:0];
                    REG_REPEAT:     thr_repeat = pwdata[RUN_W-1:0];
                    REG_NUL_PREFIX: thr_nul    = pwdata[NUL_W-1:0];
                    default: ;
                endcase
            end

            // verdict transaction against the oldest expectation
            if (m_axis_tvalid && m_axis_tready) begin
                got = verdict_t'(m_axis_tdata[4:0]);
                if (expected_verdicts.size() == 0) begin
                    bad++;
                    $display("%0t: verdict expected none, actual tdata %h",
                             $time, m_axis_tdata);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (got.is_data !== want.is_data) begin
                        bad++;
                        $display("%0t: is_data expected %0b actual %0b",
                                 $time, want.is_data, got.is_data);
                    end
                    if (got.reason !== want.reason) begin
                        bad++;
                        $display("%0t: reason expected %0d actual %0d",
                                 $time, want.reason, got.reason);
                    end
                    if (got.too_long !== want.too_long) begin
                        bad++;
                        $display("%0t: too_long expected %0b actual %0b",
                                 $time, want.too_long, got.too_long);
                    end
                end
            end

            // byte transaction
            if (s_axis_tvalid && s_axis_tready)
                tally_byte(s_axis_tdata, s_axis_tlast);

            errors      <= errors + bad;
            outstanding <= expected_verdicts.size();
        end
    end

endmodule

### tb/sv/tb_byte_region_data_classifier_core.sv
`timescale 1ns / 1ps

module tb_byte_region_data_classifier_core;
    import brdc_pkg::*;

    localparam int STALL_LIMIT  = 1000;  // cycles without any transaction
    localparam int BYTE_BUDGET  = 1550;
    localparam int PHASES       = 8;

    // Content styles of one piece of a random region
    typedef enum int {
        SEG_TEXT,
        SEG_REPEAT,
        SEG_PAIRS,
        SEG_NUL,
        SEG_NOISE
    } segment_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic [7:0]        s_axis_tdata  = '0;
    logic              s_axis_tlast  = 1'b0;
    logic              m_axis_tready = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [APB_AW-1:0] paddr         = '0;
    logic [APB_DW-1:0] pwdata        = '0;
    wire               s_axis_tready;
    wire               m_axis_tvalid;
    wire  [7:0]        m_axis_tdata;
    wire  [APB_DW-1:0] prdata;
    wire               pready;

    int                errors;
    int                outstanding;
    int                src_idle_pct  = 0;
    int                snk_stall_pct = 0;
    int                stall_left    = 0;
    int                quiet_cycles  = 0;
    int                sent_bytes    = 0;
    logic [7:0]        region[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    byte_region_data_classifier_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    brdc_verdict_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .errors        (errors),
        .outstanding   (outstanding)
    );

    // Verdict receiver: random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < snk_stall_pct) begin
            stall_left    <= $urandom_range(0, 16);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog on cycles with no transaction on either stream
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_byte_region_data_classifier_core: FAIL");
            $finish;
        end
    end

    function automatic logic [7:0] any_printable();
        logic [7:0] b;
        b[6:0] = 7'($urandom_range(32, 126));
        b[7]   = ($urandom_range(0, 3) == 0);
        return b;
    endfunction

    function automatic logic [7:0] any_control();
        case ($urandom_range(0, 6))
            0:       return 8'h00;
            1:       return 8'h0A;
            2:       return 8'h1F;
            3:       return 8'h7F;
            4:       return 8'h80;
            5:       return 8'hFF;
            default: return 8'($urandom_range(0, 31));
        endcase
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    // One byte transaction, with a random idle burst ahead of it
    task automatic put_byte(input logic [7:0] b, input logic fin);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    task automatic send_region();
        foreach (region[i])
            put_byte(region[i], i == region.size() - 1);
        sent_bytes += region.size();
    endtask

    // Append one piece of region content; a few pieces are long enough
    // to saturate the 8-bit run counters
    task automatic add_segment(input segment_t kind);
        int          n;
        int          r;
        logic [7:0]  b;
        logic [15:0] w;

        n = ($urandom_range(0, 19) == 0) ? $urandom_range(240, 300) : $urandom_range(1, 24);
        case (kind)
            SEG_TEXT:
                repeat (n)
                    region.push_back((n < 240 && $urandom_range(0, 5) == 0) ?
                                     any_control() : any_printable());
            SEG_REPEAT:
                while (n > 0) begin
                    b = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
                    r = (n >= 240) ? n : $urandom_range(1, 8);
                    if (r > n)
                        r = n;
                    repeat (r) region.push_back(b);
                    n -= r;
                end
            SEG_PAIRS:
            begin
                // keep pairs on even region offsets
                if (region.size() % 2 == 1)
                    region.push_back(8'($urandom_range(0, 255)));
                repeat ((n + 1) / 2) begin
                    case ($urandom_range(0, 7))
                        0:       w = 16'h00FF;
                        1:       w = 16'h0100;
                        2:       w = 16'h07FF;
                        3:       w = 16'h0800;
                        4, 5:    w = {8'($urandom_range(1, 7)), 8'($urandom_range(0, 255))};
                        default: w = 16'($urandom_range(0, 65535));
                    endcase
                    region.push_back(w[7:0]);
                    region.push_back(w[15:8]);
                end
            end
            SEG_NUL:
                while (n > 0) begin
                    r = $urandom_range(0, 12);
                    repeat (r) region.push_back(any_printable());
                    region.push_back(8'h00);
                    n -= r + 1;
                end
            default:
                repeat (n) region.push_back(8'($urandom_range(0, 255)));
        endcase
    endtask

    task automatic build_region();
        region.delete();
        if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 3)) region.push_back(8'($urandom_range(0, 255)));
        else
            repeat ($urandom_range(1, 3)) add_segment(segment_t'($urandom_range(0, 4)));
    endtask

    // One register write transaction: setup cycle, then access cycle
    task automatic apb_write(input reg_idx_t idx, input logic [7:0] val);
        logic [31:0] r;
        r        = $urandom();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {r[31:8], val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    // Reprogram all thresholds once every verdict has come out
    task automatic program_thresholds(input logic [7:0] lr, input logic [7:0] dr,
                                      input logic [7:0] wr, input logic [7:0] rp,
                                      input logic [3:0] np);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        apb_write(REG_LONG_RUN, lr);
        apb_write(REG_DENSE_RUN, dr);
        apb_write(REG_WORD_RUN, wr);
        apb_write(REG_REPEAT, rp);
        apb_write(REG_NUL_PREFIX, {4'($urandom_range(0, 15)), np});
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        int phase;
        int phase_goal;

        repeat (6) @(posedge clk);
        rst_n         <= 1'b1;
        src_idle_pct   = 20;
        snk_stall_pct <= 20;

        // Directed regions on the reset thresholds
        region = '{8'h41};                                  // single byte
        send_region();
        region = '{8'h00, 8'hFF, 8'h7F};                    // short, extreme bytes
        send_region();
        region = '{8'h00, 8'h00, 8'h00, 8'h00};             // identical bytes
        send_region();
        region = '{8'h61, 8'h62, 8'h63, 8'h00, 8'h01};      // zero-terminated string
        send_region();
        region = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h34, 8'h02, 8'h10, 8'h80};
        send_region();                                      // address-like pairs
        region = '{8'hC1, 8'h80, 8'hA0, 8'h0A};             // high-bit bytes, no rule
        send_region();

        sent_bytes = 0;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       program_thresholds(8'd1, 8'd1, 8'd1, 8'd2, 4'd1);
                1:       program_thresholds(8'd255, 8'd255, 8'd255, 8'd255, 4'd10);
                2:       program_thresholds(8'd0, 8'd0, 8'd0, 8'd0, 4'd0);
                3:       program_thresholds(8'd255, 8'd255, 8'd255, 8'd255, 4'd15);
                default: program_thresholds(8'($urandom_range(1, 40)), 8'($urandom_range(1, 30)),
                                            8'($urandom_range(1, 12)), 8'($urandom_range(2, 10)),
                                            4'($urandom_range(1, 10)));
            endcase

            // last phase runs without any idling
            if (phase == PHASES - 1) begin
                src_idle_pct   = 0;
                snk_stall_pct <= 0;
            end else begin
                src_idle_pct   = pick_pct();
                snk_stall_pct <= pick_pct();
            end

            phase_goal = (phase + 1) * BYTE_BUDGET / PHASES;
            while (sent_bytes < phase_goal) begin
                build_region();
                send_region();
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("tb_byte_region_data_classifier_core: PASS");
        else
            $display("tb_byte_region_data_classifier_core: FAIL");
        $finish;
    end

endmodule
